// ===== src/clcd_pkg.sv =====
// Shared constants, types and the control program of the character LCD bus sequencer.
package clcd_pkg;

  localparam int LINE_LENGTH = 16;
  localparam int CNT_W       = $clog2(2 * LINE_LENGTH + 1);
  localparam int PC_W        = 4;

  // Request codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PRINT = 2'd1;
  localparam logic [1:0] CMD_GOTO  = 2'd2;
  localparam logic [1:0] CMD_INIT  = 2'd3;

  // Strobe phases within one byte.
  localparam logic [1:0] PH_BUSY = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Flow control of a program step, applied once its byte has gone out.
  localparam logic [2:0] FLOW_NEXT = 3'd0;
  localparam logic [2:0] FLOW_END  = 3'd1;
  localparam logic [2:0] FLOW_WRAP = 3'd2;
  localparam logic [2:0] FLOW_MODE = 3'd3;
  localparam logic [2:0] FLOW_JUMP = 3'd4;

  // Display instruction bytes.
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_RET_HOME   = 8'h02;
  localparam logic [7:0] LCD_FUNC_8BIT  = 8'h38;
  localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] LCD_DISP_ON    = 8'h0F;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'b0000_0110;
  localparam logic [7:0] LCD_ROW0       = 8'h80;
  localparam logic [7:0] LCD_ROW1       = 8'hC0;
  localparam logic [7:0] NIBBLE_MASK    = 8'hF0;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_WRITE      = 4'd0;
  localparam logic [PC_W-1:0] PC_PRINT      = 4'd1;
  localparam logic [PC_W-1:0] PC_PAGE_CLEAR = 4'd2;
  localparam logic [PC_W-1:0] PC_PAGE_HOME  = 4'd3;
  localparam logic [PC_W-1:0] PC_LINE_WRAP  = 4'd4;
  localparam logic [PC_W-1:0] PC_GOTO       = 4'd5;
  localparam logic [PC_W-1:0] PC_INIT       = 4'd6;
  localparam logic [PC_W-1:0] PC_INIT_RET   = 4'd7;
  localparam logic [PC_W-1:0] PC_INIT_F4    = 4'd8;
  localparam logic [PC_W-1:0] PC_INIT_F8    = 4'd9;
  localparam logic [PC_W-1:0] PC_INIT_DISP  = 4'd10;
  localparam logic [PC_W-1:0] PC_INIT_CLR   = 4'd11;
  localparam logic [PC_W-1:0] PC_INIT_ENTRY = 4'd12;

  typedef struct packed {
    logic            use_data;
    logic            rs;
    logic [2:0]      flow;
    logic [PC_W-1:0] target;
    logic [7:0]      value;
  } ctrl_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       drive;
    logic [7:0] value;
  } strobe_t;

  // One control word per step; each step sends one byte to the display.
  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      PC_WRITE: begin
        w.use_data = 1'b1;
        w.flow     = FLOW_END;
      end
      PC_PRINT: begin
        w.use_data = 1'b1;
        w.rs       = 1'b1;
        w.flow     = FLOW_WRAP;
        w.target   = PC_LINE_WRAP;
      end
      PC_PAGE_CLEAR: begin
        w.value = LCD_CLEAR;
        w.flow  = FLOW_NEXT;
      end
      PC_PAGE_HOME: begin
        w.value = LCD_ROW0;
        w.flow  = FLOW_END;
      end
      PC_LINE_WRAP: begin
        w.value = LCD_ROW1;
        w.flow  = FLOW_END;
      end
      PC_GOTO: begin
        w.use_data = 1'b1;
        w.flow     = FLOW_END;
      end
      PC_INIT: begin
        w.value  = LCD_CLEAR;
        w.flow   = FLOW_MODE;
        w.target = PC_INIT_F8;
      end
      PC_INIT_RET: begin
        w.value = LCD_RET_HOME;
        w.flow  = FLOW_NEXT;
      end
      PC_INIT_F4: begin
        w.value  = LCD_FUNC_4BIT;
        w.flow   = FLOW_JUMP;
        w.target = PC_INIT_DISP;
      end
      PC_INIT_F8: begin
        w.value = LCD_FUNC_8BIT;
        w.flow  = FLOW_NEXT;
      end
      PC_INIT_DISP: begin
        w.value = LCD_DISP_ON;
        w.flow  = FLOW_NEXT;
      end
      PC_INIT_CLR: begin
        w.value = LCD_CLEAR;
        w.flow  = FLOW_NEXT;
      end
      PC_INIT_ENTRY: begin
        w.value = LCD_ENTRY_MODE;
        w.flow  = FLOW_END;
      end
      default: begin
        w.flow = FLOW_END;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/clcd_strobe_gen.sv =====
// Strobe generator: turns one byte and a phase into busy-read, full or nibble bus values.
module clcd_strobe_gen
  import clcd_pkg::*;
(
  input  logic [7:0] byte_in,
  input  logic       rs_in,
  input  logic [1:0] phase,
  input  logic       four_bit,
  output strobe_t    strobe,
  output logic       byte_done
);

  always_comb begin
    strobe    = '0;
    byte_done = 1'b0;
    case (phase)
      PH_BUSY: begin
        strobe.rw = 1'b1;
      end
      PH_HIGH: begin
        strobe.rs    = rs_in;
        strobe.drive = 1'b1;
        if (four_bit) begin
          strobe.value = byte_in & NIBBLE_MASK;
        end else begin
          strobe.value = byte_in;
          byte_done    = 1'b1;
        end
      end
      PH_LOW: begin
        strobe.rs    = rs_in;
        strobe.drive = 1'b1;
        strobe.value = {byte_in[3:0], 4'b0000};
        byte_done    = 1'b1;
      end
      default: begin
        byte_done = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/char_lcd_bus_sequencer.sv =====
// Character LCD bus sequencer top level: request intake, program counter and strobe register.
//
// Requests arrive on the in_ channel (valid/stall): a command byte, a printed
// character, a go-to of row and column, or the initialisation sequence. Each
// request becomes a run of strobe items on the out_ channel (valid/stall), one
// per cycle while the receiver does not stall; out_last marks the final one.
// Every byte is a busy-check read followed by one eight-bit write or two
// nibble writes, as chosen by the nibble mode register on the cfg_ port.
// A taken request is held in the step registers, and each strobe it makes is
// then registered in the output register. A request gives 2 or 3 strobes for
// a command or go-to, up to 9 for a printed character that wraps the page,
// and 10 or 18 for initialisation. The step counter walks a small control
// program, one byte per step, so the strobe count is the number of bytes
// times the strobes per byte. The next request is taken in the cycle after
// the last strobe has entered the output register, so no request is taken
// before the last one is through. An invalid go-to is taken and gives no
// strobes. A stall on out_ holds the strobe register and the sequencer.
// Reset clears the character count, the mode and the output valid.
module char_lcd_bus_sequencer
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_byte_value,
  input  logic       in_new_string,
  input  logic [1:0] in_row,
  input  logic [4:0] in_column,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_nibble_mode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_register_select,
  output logic       out_read_not_write,
  output logic       out_drive_bus,
  output logic [7:0] out_bus_value,
  output logic       out_last
);

  logic             busy_r, busy_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             mode_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wrap_line_r, wrap_line_nxt;
  logic             wrap_page_r, wrap_page_nxt;
  logic             out_valid_r, out_valid_nxt;
  strobe_t          strobe_r;
  logic             last_r;

  logic             accept, advance;
  logic [CNT_W-1:0] cnt_inc;
  logic             goto_ok;
  logic [7:0]       goto_byte;
  ctrl_t            word;
  strobe_t          strobe;
  logic             byte_done, step_end;

  assign in_stall  = busy_r;
  assign cfg_ready = !busy_r && !out_valid_r;
  assign accept    = in_valid && !busy_r;
  assign advance   = busy_r && (!out_valid_r || !out_stall);

  assign cnt_inc   = (in_new_string ? '0 : count_r) + CNT_W'(1);
  assign goto_ok   = !in_row[1] && (int'(in_column) < LINE_LENGTH);
  assign goto_byte = (in_row[0] ? LCD_ROW1 : LCD_ROW0) + {3'b000, in_column};

  assign word = rom_word(pc_r);

  clcd_strobe_gen u_strobe (
    .byte_in   (word.use_data ? data_r : word.value),
    .rs_in     (word.rs),
    .phase     (phase_r),
    .four_bit  (mode_r),
    .strobe    (strobe),
    .byte_done (byte_done)
  );

  // A wrapping character ends the request only when neither wrap is due.
  always_comb begin
    case (word.flow)
      FLOW_END:  step_end = 1'b1;
      FLOW_WRAP: step_end = !(wrap_line_r || wrap_page_r);
      default:   step_end = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    phase_nxt     = phase_r;
    data_nxt      = data_r;
    count_nxt     = count_r;
    wrap_line_nxt = wrap_line_r;
    wrap_page_nxt = wrap_page_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (accept) begin
      phase_nxt     = PH_BUSY;
      data_nxt      = in_byte_value;
      wrap_line_nxt = 1'b0;
      wrap_page_nxt = 1'b0;
      case (in_cmd)
        CMD_WRITE: begin
          busy_nxt = 1'b1;
          pc_nxt   = PC_WRITE;
        end
        CMD_PRINT: begin
          busy_nxt      = 1'b1;
          pc_nxt        = PC_PRINT;
          wrap_line_nxt = (cnt_inc == CNT_W'(LINE_LENGTH));
          wrap_page_nxt = (cnt_inc >= CNT_W'(2 * LINE_LENGTH));
          count_nxt     = wrap_page_nxt ? '0 : cnt_inc;
        end
        CMD_GOTO: begin
          busy_nxt = goto_ok;
          pc_nxt   = PC_GOTO;
          data_nxt = goto_byte;
        end
        CMD_INIT: begin
          busy_nxt = 1'b1;
          pc_nxt   = PC_INIT;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
      if (byte_done) begin
        phase_nxt = PH_BUSY;
        if (step_end) begin
          busy_nxt = 1'b0;
        end else begin
          case (word.flow)
            FLOW_WRAP: pc_nxt = wrap_page_r ? pc_r + PC_W'(1) : word.target;
            FLOW_MODE: pc_nxt = mode_r ? pc_r + PC_W'(1) : word.target;
            FLOW_JUMP: pc_nxt = word.target;
            default:   pc_nxt = pc_r + PC_W'(1);
          endcase
        end
      end else begin
        phase_nxt = (phase_r == PH_BUSY) ? PH_HIGH : PH_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= PC_WRITE;
      phase_r     <= PH_BUSY;
      mode_r      <= 1'b0;
      count_r     <= '0;
      wrap_line_r <= 1'b0;
      wrap_page_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      wrap_line_r <= wrap_line_nxt;
      wrap_page_r <= wrap_page_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_nibble_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (advance) begin
      strobe_r <= strobe;
      last_r   <= byte_done && step_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = strobe_r.rs;
  assign out_read_not_write  = strobe_r.rw;
  assign out_drive_bus       = strobe_r.drive;
  assign out_bus_value       = strobe_r.value;
  assign out_last            = last_r;

endmodule

// ===== src/clcd_checker.sv =====
// Port-level checker for the character LCD bus sequencer and its bind statement.
module clcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_register_select,
  input logic       out_read_not_write,
  input logic       out_drive_bus,
  input logic [7:0] out_bus_value,
  input logic       out_last
);

  // A busy read releases the bus and shows instruction select with zero data.
  a_busy_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_not_write |->
      !out_drive_bus && !out_register_select && (out_bus_value == 8'h00))
    else $error("busy read strobe drives the bus or carries data");

  // Every byte ends with a write, so a busy read is never the final strobe.
  a_read_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_not_write |-> !out_last)
    else $error("busy read strobe marked as last");

  // A write strobe always drives the data lines.
  a_write_drives: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_not_write |-> out_drive_bus)
    else $error("write strobe with bus released");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bus_value) && $stable(out_last))
    else $error("stalled strobe item changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind char_lcd_bus_sequencer clcd_checker u_clcd_checker (.*);
